// ===== sv/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Operation and status codes and the saturation helper for the complex ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package cau_pkg;

	localparam logic [2:0] MODE_ADD  = 3'd0;
	localparam logic [2:0] MODE_SUB  = 3'd1;
	localparam logic [2:0] MODE_MUL  = 3'd2;
	localparam logic [2:0] MODE_DIV  = 3'd3;
	localparam logic [2:0] MODE_CONJ = 3'd4;
	localparam logic [2:0] MODE_POW  = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DIVZERO = 2'd1;
	localparam logic [1:0] ST_OVF     = 2'd2;

	typedef struct packed {
		logic        ovf;
		logic [31:0] val;
	} sat_t;

	// sign and magnitude to 32-bit two's complement, clipped
	function automatic sat_t sat_mag(input logic neg, input logic [64:0] mag);
		sat_t r;
		r.ovf = 1'b0;
		if (neg) begin
			if (mag > 65'h0_8000_0000) begin
				r.ovf = 1'b1;
				r.val = 32'h8000_0000;
			end else begin
				r.val = 32'(65'd0 - mag);
			end
		end else begin
			if (mag > 65'h0_7FFF_FFFF) begin
				r.ovf = 1'b1;
				r.val = 32'h7FFF_FFFF;
			end else begin
				r.val = mag[31:0];
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/cau_mul.sv =====
// ----------------------------------------------------------------------------
// cau_mul
// Shared signed 32x32 multiplier, result as sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_mul (
	input  wire logic signed [31:0] x,
	input  wire logic signed [31:0] y,
	output logic             [63:0] mag,
	output logic                    neg
);
	logic [31:0] x_abs, y_abs;

	assign x_abs = x[31] ? 32'd0 - 32'(x) : 32'(x);
	assign y_abs = y[31] ? 32'd0 - 32'(y) : 32'(y);
	assign mag   = {32'd0, x_abs} * {32'd0, y_abs};
	// a zero product with the sign set still adds as zero
	assign neg   = x[31] ^ y[31];

endmodule
`default_nettype wire

// ===== sv/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide, conjugate and integer power on
// signed fixed-point operands, built round one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  direction  word                                    handshake
//  s_*      in         mode, a_re, a_im, b_re, b_im, exponent  tvalid/tready
//  m_*      out        res_re, res_im, status                  tvalid/tready
//
//  add, subtract, conjugate, spare codes: result registered on accept, then output
//  multiply: four products in turn, a combine, then output; power: e-1 steps,
//  each forming four products and a combine, then output
//  divide: six products in turn, a setup, 64+FRAC_BITS restoring divide steps,
//  a clip, then output
//  s_tready is high only while the sequencer is idle; a result waiting on
//  m_tready does not hold off the next word. reset clears control only
// ----------------------------------------------------------------------------
`default_nettype none
module complex_arithmetic_unit #(
	parameter int MAX_EXPONENT = 63,
	parameter int FRAC_BITS    = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// mode[2:0], a_re[34:3], a_im[66:35], b_re[98:67], b_im[130:99],
	// exponent[136:131], zero fill
	input  wire logic [143:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// res_re[31:0], res_im[63:32], status[65:64], zero fill
	output logic [71:0]       m_tdata
);
	import cau_pkg::*;

	localparam int DW = 64 + FRAC_BITS;
	localparam int CW = $clog2(DW);
	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_COMB, S_DINIT, S_DIV, S_DEND, S_FIN
	} state_t;

	state_t state_q;
	logic [2:0]  mode_q, k_q;
	logic signed [31:0] a_re_q, a_im_q, b_re_q, b_im_q, res_re_q, res_im_q;
	logic [5:0]  pcnt_q;
	logic        ovf_q, dz_q;
	logic [63:0] p_mag_q [6];
	logic        p_neg_q [6];
	logic [63:0] d_q;
	logic [DW-1:0] dvd_re_q, dvd_im_q;
	logic [64:0] rem_re_q, rem_im_q;
	logic [33:0] quo_re_q, quo_im_q;
	logic        qn_re_q, qn_im_q;
	logic [CW-1:0] cnt_q;
	logic        out_valid_q;
	logic [71:0] out_q;

	// incoming fields
	logic [2:0]  in_mode;
	logic signed [31:0] in_are, in_aim, in_bre, in_bim;
	logic [5:0]  in_exp, e_cl;
	assign in_mode = s_tdata[2:0];
	assign in_are  = s_tdata[34:3];
	assign in_aim  = s_tdata[66:35];
	assign in_bre  = s_tdata[98:67];
	assign in_bim  = s_tdata[130:99];
	assign in_exp  = s_tdata[136:131];
	assign e_cl    = ({2'b00, in_exp} > 8'(MAX_EXPONENT)) ? 6'(MAX_EXPONENT) : in_exp;

	// add, subtract, conjugate
	logic signed [32:0] sum_re, sum_im;
	logic [32:0] abs_re, abs_im;
	sat_t sa_re, sa_im;
	always_comb begin
		sum_re = 33'(in_are) + 33'(in_bre);
		sum_im = 33'(in_aim) + 33'(in_bim);
		if (in_mode == MODE_SUB) begin
			sum_re = 33'(in_are) - 33'(in_bre);
			sum_im = 33'(in_aim) - 33'(in_bim);
		end else if (in_mode == MODE_CONJ) begin
			sum_re = 33'(in_are);
			sum_im = 33'sd0 - 33'(in_aim);
		end
		abs_re = sum_re[32] ? 33'd0 - 33'(sum_re) : 33'(sum_re);
		abs_im = sum_im[32] ? 33'd0 - 33'(sum_im) : 33'(sum_im);
		sa_re  = sat_mag(sum_re[32], {32'd0, abs_re});
		sa_im  = sat_mag(sum_im[32], {32'd0, abs_im});
	end

	// shared multiplier operand select
	logic signed [31:0] x_re, x_im, y_re, y_im, mx, my;
	logic [63:0] m_mag;
	logic        m_neg;
	always_comb begin
		x_re = (mode_q == MODE_POW) ? res_re_q : a_re_q;
		x_im = (mode_q == MODE_POW) ? res_im_q : a_im_q;
		y_re = (mode_q == MODE_POW) ? a_re_q : b_re_q;
		y_im = (mode_q == MODE_POW) ? a_im_q : b_im_q;
		unique case (k_q)
			3'd0:    begin mx = x_re;   my = y_re;   end
			3'd1:    begin mx = x_im;   my = y_im;   end
			3'd2:    begin mx = x_re;   my = y_im;   end
			3'd3:    begin mx = x_im;   my = y_re;   end
			3'd4:    begin mx = b_re_q; my = b_re_q; end
			default: begin mx = b_im_q; my = b_im_q; end
		endcase
	end

	cau_mul u_mul (.x(mx), .y(my), .mag(m_mag), .neg(m_neg));

	// products as signed values
	logic signed [65:0] s0, s1, s2, s3, c_re, c_im, n_re, n_im;
	logic [65:0] cm_re, cm_im, nm_re, nm_im;
	sat_t sc_re, sc_im, sq_re, sq_im;
	always_comb begin
		s0 = p_neg_q[0] ? 66'sd0 - $signed({2'b00, p_mag_q[0]}) : $signed({2'b00, p_mag_q[0]});
		s1 = p_neg_q[1] ? 66'sd0 - $signed({2'b00, p_mag_q[1]}) : $signed({2'b00, p_mag_q[1]});
		s2 = p_neg_q[2] ? 66'sd0 - $signed({2'b00, p_mag_q[2]}) : $signed({2'b00, p_mag_q[2]});
		s3 = p_neg_q[3] ? 66'sd0 - $signed({2'b00, p_mag_q[3]}) : $signed({2'b00, p_mag_q[3]});
		c_re  = s0 - s1;
		c_im  = s2 + s3;
		n_re  = s0 + s1;
		n_im  = s3 - s2;
		cm_re = c_re[65] ? 66'd0 - 66'(c_re) : 66'(c_re);
		cm_im = c_im[65] ? 66'd0 - 66'(c_im) : 66'(c_im);
		nm_re = n_re[65] ? 66'd0 - 66'(n_re) : 66'(n_re);
		nm_im = n_im[65] ? 66'd0 - 66'(n_im) : 66'(n_im);
		sc_re = sat_mag(c_re[65], 65'(cm_re >> FRAC_BITS));
		sc_im = sat_mag(c_im[65], 65'(cm_im >> FRAC_BITS));
		sq_re = sat_mag(qn_re_q, {31'd0, quo_re_q});
		sq_im = sat_mag(qn_im_q, {31'd0, quo_im_q});
	end

	// one restoring step for each part
	logic [64:0] rs_re, rs_im, rn_re, rn_im;
	logic        ge_re, ge_im;
	always_comb begin
		rs_re = {rem_re_q[63:0], dvd_re_q[DW-1]};
		rs_im = {rem_im_q[63:0], dvd_im_q[DW-1]};
		ge_re = rs_re >= {1'b0, d_q};
		ge_im = rs_im >= {1'b0, d_q};
		rn_re = ge_re ? rs_re - {1'b0, d_q} : rs_re;
		rn_im = ge_im ? rs_im - {1'b0, d_q} : rs_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			cnt_q       <= '0;
		end else begin
			if (state_q == S_FIN && (!out_valid_q || m_tready)) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						mode_q <= in_mode;
						a_re_q <= in_are;
						a_im_q <= in_aim;
						b_re_q <= in_bre;
						b_im_q <= in_bim;
						ovf_q  <= 1'b0;
						dz_q   <= 1'b0;
						k_q    <= '0;
						state_q <= S_FIN;
						priority if (in_mode == MODE_ADD || in_mode == MODE_SUB ||
								in_mode == MODE_CONJ) begin
							res_re_q <= sa_re.val;
							res_im_q <= sa_im.val;
							ovf_q    <= sa_re.ovf | sa_im.ovf;
						end else if (in_mode == MODE_MUL) begin
							state_q <= S_MUL;
						end else if (in_mode == MODE_DIV) begin
							res_re_q <= '0;
							res_im_q <= '0;
							if (in_bre == 32'sd0 && in_bim == 32'sd0) dz_q <= 1'b1;
							else state_q <= S_MUL;
						end else if (in_mode == MODE_POW) begin
							res_re_q <= (e_cl == 6'd0) ? $signed(ONE) : in_are;
							res_im_q <= (e_cl == 6'd0) ? 32'sd0 : in_aim;
							pcnt_q   <= e_cl - 6'd1;
							if (e_cl > 6'd1) state_q <= S_MUL;
						end else begin
							res_re_q <= '0;
							res_im_q <= '0;
						end
					end
				end
				S_MUL: begin
					p_mag_q[k_q] <= m_mag;
					p_neg_q[k_q] <= m_neg;
					if (k_q == ((mode_q == MODE_DIV) ? 3'd5 : 3'd3)) begin
						k_q     <= '0;
						state_q <= (mode_q == MODE_DIV) ? S_DINIT : S_COMB;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				S_COMB: begin
					res_re_q <= sc_re.val;
					res_im_q <= sc_im.val;
					ovf_q    <= ovf_q | sc_re.ovf | sc_im.ovf;
					if (mode_q == MODE_POW && pcnt_q != 6'd1) begin
						pcnt_q  <= pcnt_q - 6'd1;
						state_q <= S_MUL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DINIT: begin
					d_q      <= p_mag_q[4] + p_mag_q[5];
					dvd_re_q <= {nm_re[63:0], FRAC_BITS'(0)};
					dvd_im_q <= {nm_im[63:0], FRAC_BITS'(0)};
					qn_re_q  <= n_re[65];
					qn_im_q  <= n_im[65];
					rem_re_q <= '0;
					rem_im_q <= '0;
					quo_re_q <= '0;
					quo_im_q <= '0;
					cnt_q    <= '0;
					state_q  <= S_DIV;
				end
				S_DIV: begin
					rem_re_q <= rn_re;
					rem_im_q <= rn_im;
					dvd_re_q <= dvd_re_q << 1;
					dvd_im_q <= dvd_im_q << 1;
					// quotient stops growing once far past the clip level
					if (!quo_re_q[33]) quo_re_q <= {quo_re_q[32:0], ge_re};
					if (!quo_im_q[33]) quo_im_q <= {quo_im_q[32:0], ge_im};
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(DW - 1)) state_q <= S_DEND;
				end
				S_DEND: begin
					res_re_q <= sq_re.val;
					res_im_q <= sq_im.val;
					ovf_q    <= sq_re.ovf | sq_im.ovf;
					state_q  <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || m_tready) begin
						out_q <= {6'd0,
							dz_q ? ST_DIVZERO : (ovf_q ? ST_OVF : ST_OK),
							res_im_q, res_re_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready || m_tvalid)
		else $error("input taken while a word was still in progress");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[65:64] != 2'd3)
		else $error("undefined status code");
	a_divzero_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[65:64] == ST_DIVZERO |-> m_tdata[63:0] == 64'd0)
		else $error("division by zero with non-zero result");
	a_pow_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL && mode_q == MODE_POW |-> pcnt_q != 6'd0)
		else $error("power step count ran out");

endmodule
`default_nettype wire

// ===== tb/sv/tb_complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Drives operand words through the complex ALU under random stalls on both
// sides (none in the last run) and checks every result word against an in-bench predictor.
// ----------------------------------------------------------------------------
import cau_pkg::*;

typedef struct {
	logic [2:0]  mode;
	logic [31:0] a_re;
	logic [31:0] a_im;
	logic [31:0] b_re;
	logic [31:0] b_im;
	logic [5:0]  exponent;
} cplx_op_t;

typedef struct {
	logic [31:0] res_re;
	logic [31:0] res_im;
	logic [1:0]  status;
} cplx_res_t;

class cplx_result_check;
	cplx_res_t pending_results[$];
	int        mismatches;

	// clip to 32 bits after dropping shift fraction bits, truncating toward zero
	function logic [31:0] clip_part(input logic signed [127:0] v, input int shift,
			inout bit ovf);
		logic [127:0] mag;
		logic         neg;
		neg = v < 0;
		mag = neg ? 128'(-v) : 128'(v);
		mag = mag >> shift;
		if (neg && mag > 128'h8000_0000) begin
			ovf = 1'b1;
			return 32'h8000_0000;
		end
		if (!neg && mag > 128'h7FFF_FFFF) begin
			ovf = 1'b1;
			return 32'h7FFF_FFFF;
		end
		return neg ? 32'(128'd0 - mag) : mag[31:0];
	endfunction

	function void cplx_mul(input logic signed [127:0] xr, xi, yr, yi,
			output logic [31:0] pr, pi, inout bit ovf);
		pr = clip_part(xr * yr - xi * yi, 16, ovf);
		pi = clip_part(xr * yi + xi * yr, 16, ovf);
	endfunction

	function cplx_res_t predict_cplx(input cplx_op_t op);
		cplx_res_t              r;
		bit                     ovf;
		logic signed [127:0]    ar, ai, br, bi, d, num;
		logic [127:0]           mag, q;
		logic [31:0]            tr, ti;
		ar = 128'(signed'(op.a_re));
		ai = 128'(signed'(op.a_im));
		br = 128'(signed'(op.b_re));
		bi = 128'(signed'(op.b_im));
		ovf = 1'b0;
		r.res_re = '0;
		r.res_im = '0;
		r.status = ST_OK;
		case (op.mode)
			MODE_ADD: begin
				r.res_re = clip_part(ar + br, 0, ovf);
				r.res_im = clip_part(ai + bi, 0, ovf);
			end
			MODE_SUB: begin
				r.res_re = clip_part(ar - br, 0, ovf);
				r.res_im = clip_part(ai - bi, 0, ovf);
			end
			MODE_MUL: cplx_mul(ar, ai, br, bi, r.res_re, r.res_im, ovf);
			MODE_DIV: begin
				if (br == 0 && bi == 0) begin
					r.status = ST_DIVZERO;
				end else begin
					d = br * br + bi * bi;
					num = ar * br + ai * bi;
					mag = num < 0 ? 128'(-num) : 128'(num);
					q = (mag << 16) / 128'(d);
					r.res_re = clip_part(num < 0 ? -$signed(q) : $signed(q), 0, ovf);
					num = ai * br - ar * bi;
					mag = num < 0 ? 128'(-num) : 128'(num);
					q = (mag << 16) / 128'(d);
					r.res_im = clip_part(num < 0 ? -$signed(q) : $signed(q), 0, ovf);
				end
			end
			MODE_CONJ: begin
				r.res_re = op.a_re;
				r.res_im = clip_part(-ai, 0, ovf);
			end
			MODE_POW: begin
				if (op.exponent == 0) begin
					r.res_re = 32'h0001_0000;
				end else begin
					r.res_re = op.a_re;
					r.res_im = op.a_im;
					for (int k = 1; k < op.exponent; k++) begin
						cplx_mul(128'(signed'(r.res_re)), 128'(signed'(r.res_im)),
							ar, ai, tr, ti, ovf);
						r.res_re = tr;
						r.res_im = ti;
					end
				end
			end
			default: ;
		endcase
		if (r.status == ST_OK && ovf)
			r.status = ST_OVF;
		return r;
	endfunction

	function void note_operands(input cplx_op_t op);
		pending_results.push_back(predict_cplx(op));
	endfunction

	function void check_result(input logic [71:0] word);
		cplx_res_t want;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result word %h", word);
			return;
		end
		want = pending_results.pop_front();
		if (word[31:0] !== want.res_re || word[63:32] !== want.res_im ||
				word[65:64] !== want.status) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected re %h im %h st %0d, got re %h im %h st %0d",
					want.res_re, want.res_im, want.status,
					word[31:0], word[63:32], word[65:64]);
		end
	endfunction
endclass

module tb_complex_arithmetic_unit;
	// codes the package leaves unnamed
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;
	localparam int DRAIN_CYCLES = 400;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;

	int src_idle_pct;
	int dst_idle_pct;

	cplx_result_check results = new();

	complex_arithmetic_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	// result side: check on handshake, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			results.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= dst_idle_pct);
	end

	// valid stays up after an accept until the next word or an idle cycle replaces it
	task automatic send_word(input cplx_op_t op);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, op.exponent, op.b_im, op.b_re, op.a_im, op.a_re, op.mode};
		do @(posedge clk); while (!s_tready);
		results.note_operands(op);
	endtask

	task automatic send_op(input logic [2:0] mode, input logic [31:0] ar, ai, br, bi,
			input logic [5:0] e);
		cplx_op_t op;
		op = '{mode, ar, ai, br, bi, e};
		send_word(op);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (results.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_part();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(262143)) - 131072);
			2: return 32'h0001_0000 + 32'($signed($urandom_range(8191)) - 4096);
			default: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'd0;
					default: return 32'hFFFF_0000;
				endcase
			end
		endcase
	endfunction

	task automatic send_random(input int count);
		cplx_op_t op;
		for (int n = 0; n < count; n++) begin
			op.mode = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
				: 3'($urandom_range(5));
			op.a_re = pick_part();
			op.a_im = pick_part();
			op.b_re = pick_part();
			op.b_im = pick_part();
			if ($urandom_range(9) == 0) begin
				op.b_re = '0;
				op.b_im = '0;
			end
			op.exponent = $urandom_range(63);
			send_word(op);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		src_idle_pct = 11;
		dst_idle_pct = 55;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// edges of the number range and each mode
		send_op(MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 6'd0);
		send_op(MODE_ADD, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_4000, 32'h0002_0000, 6'd63);
		send_op(MODE_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 6'd0);
		send_op(MODE_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 6'd5);
		send_op(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 6'd0);
		send_op(MODE_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 6'd0);
		send_op(MODE_MUL, 32'h0002_0000, 32'hFFFF_8000, 32'h0001_8000, 32'h0000_C000, 6'd1);
		// zero denominator
		send_op(MODE_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 6'd0);
		send_op(MODE_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000, 6'd0);
		send_op(MODE_DIV, 32'h0003_0000, 32'hFFFE_0000, 32'h0001_0000, 32'h0001_0000, 6'd0);
		send_op(MODE_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 6'd0);
		send_op(MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001, 6'd63);
		// negating the most negative value
		send_op(MODE_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 6'd0);
		send_op(MODE_CONJ, 32'h1234_5678, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1, 6'd63);
		// power: zero exponent, unit exponent, longest chain, growing operand
		send_op(MODE_POW, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 6'd0);
		send_op(MODE_POW, 32'h0001_8000, 32'hFFFF_0000, 32'h0, 32'h0, 6'd1);
		send_op(MODE_POW, 32'h0001_0000, 32'h0000_0000, 32'h0, 32'h0, 6'd63);
		send_op(MODE_POW, 32'h0000_0000, 32'h0001_0000, 32'h0, 32'h0, 6'd63);
		send_op(MODE_POW, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0, 6'd40);
		send_op(MODE_POW, 32'h0000_F000, 32'h0000_1000, 32'h0, 32'h0, 6'd17);
		send_op(MODE_SPARE6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
		send_op(MODE_SPARE7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h2, 6'd3);
		send_random(430);

		// sender holds off until the block has emptied
		drain();
		src_idle_pct = 55;
		dst_idle_pct = 11;
		send_random(450);

		drain();
		src_idle_pct = 0;
		dst_idle_pct = 0;
		send_random(450);

		drain();
		if (results.mismatches == 0 && results.pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
